// ----- rtl/idc_pkg.sv -----
package idc_pkg;

	localparam int WindowDepth    = 8192;
	localparam int BytesPerResult = 16;
	localparam int MaxCodeLength  = 16;

	localparam logic REG_THREE_TREES = 1'b0;
	localparam logic REG_LARGE_DICT  = 1'b1;

	localparam logic [3:0] PH_LIT_HDR  = 4'd0;
	localparam logic [3:0] PH_LEN_HDR  = 4'd1;
	localparam logic [3:0] PH_DIST_HDR = 4'd2;
	localparam logic [3:0] PH_FLAG     = 4'd3;
	localparam logic [3:0] PH_LIT      = 4'd4;
	localparam logic [3:0] PH_RAW      = 4'd5;
	localparam logic [3:0] PH_DLOW     = 4'd6;
	localparam logic [3:0] PH_DHIGH    = 4'd7;
	localparam logic [3:0] PH_LEN      = 4'd8;
	localparam logic [3:0] PH_EXTRA    = 4'd9;
	localparam logic [3:0] PH_STOPPED  = 4'd10;

	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_PAIR  = 2'd1;
	localparam logic [1:0] OP_BUILD = 2'd2;
	localparam logic [1:0] OP_LOOK  = 2'd3;

	localparam logic [1:0] TREE_LIT  = 2'd0;
	localparam logic [1:0] TREE_LEN  = 2'd1;
	localparam logic [1:0] TREE_DIST = 2'd2;

	localparam logic [5:0] LenCodeExtra = 6'h3f;

	typedef struct packed {
		logic [1:0]  op;
		logic [1:0]  tree;
		logic [7:0]  pair;
		logic [15:0] code;
		logic [4:0]  clen;
	} tree_req_t;

	typedef struct packed {
		logic       done;
		logic       ok;
		logic [7:0] sym;
	} tree_rsp_t;

	function automatic logic [8:0] tree_base(input logic [1:0] t);
		logic [8:0] b;
		b = 9'd0;
		case (t)
			TREE_LEN:  b = 9'd256;
			TREE_DIST: b = 9'd320;
			default:   b = 9'd0;
		endcase
		return b;
	endfunction

	function automatic logic [8:0] tree_size(input logic [1:0] t);
		logic [8:0] n;
		n = 9'd64;
		case (t)
			TREE_LIT: n = 9'd256;
			default:  n = 9'd64;
		endcase
		return n;
	endfunction

endpackage

// ----- rtl/idc_window.sv -----
module idc_window
	import idc_pkg::*;
#(
	parameter int WINDOW_DEPTH = WindowDepth
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [7:0]                      wdata,
	input  logic                            re,
	input  logic [$clog2(WINDOW_DEPTH)-1:0] raddr,
	output logic [7:0]                      rdata,
	output logic [$clog2(WINDOW_DEPTH)-1:0] pos
);

	localparam int AW = $clog2(WINDOW_DEPTH);

	logic [7:0]    mem [WINDOW_DEPTH];
	logic [7:0]    rd_q;
	logic          rv_q;
	logic [AW-1:0] pos_q;
	logic          wrapped_q;

	// entries not yet written since reset read as zero
	always_ff @(posedge clk) begin
		if (we)
			mem[pos_q] <= wdata;
		if (re)
			rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			wrapped_q <= 1'b0;
			rv_q      <= 1'b0;
		end else begin
			if (re)
				rv_q <= wrapped_q || (raddr < pos_q);
			if (we) begin
				if (pos_q == AW'(WINDOW_DEPTH - 1)) begin
					pos_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	assign rdata = rv_q ? rd_q : 8'd0;
	assign pos   = pos_q;

endmodule

// ----- rtl/idc_tree.sv -----
module idc_tree
	import idc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  tree_req_t req,
	output tree_rsp_t rsp
);

	localparam logic [2:0] T_IDLE  = 3'd0;
	localparam logic [2:0] T_PAIR  = 3'd1;
	localparam logic [2:0] T_SWEEP = 3'd2;
	localparam logic [2:0] T_SORT  = 3'd3;
	localparam logic [2:0] T_SORTW = 3'd4;
	localparam logic [2:0] T_LOOK1 = 3'd5;
	localparam logic [2:0] T_LOOK2 = 3'd6;

	logic [2:0]  st_q;
	logic [1:0]  t_q;
	logic [8:0]  pos_q;
	logic        over_q;
	logic [8:0]  cnt_q [MaxCodeLength];
	logic [8:0]  cur_q [MaxCodeLength];
	logic [4:0]  reps_q;
	logic [3:0]  len_q;
	logic [4:0]  sl_q;
	logic [24:0] code_q;
	logic [8:0]  off_q;
	logic [8:0]  s_q;
	logic [15:0] lc_q;
	logic        sv_s1;
	logic [7:0]  ss_s1;
	logic        done_q;
	logic        ok_q;
	logic [7:0]  sym_q;

	// code lengths (minus one), decode table {first code, count, offset}, sorted symbols
	logic [3:0]  lmem [384];
	logic [33:0] tmem [48];
	logic [7:0]  smem [384];
	logic [3:0]  lrd_q;
	logic [33:0] trd_q;
	logic [7:0]  srd_q;

	logic        l_we, l_re, t_we, t_re, s_we, s_re;
	logic [8:0]  l_wa, l_ra, s_wa, s_ra;
	logic [5:0]  t_wa, t_ra;
	logic [33:0] t_wd;
	logic [8:0]  base, size;
	logic        full;
	logic [3:0]  sidx;
	logic [15:0] fc, lfc, d;
	logic [8:0]  lcnt, loff;
	logic        hit;

	always_comb begin
		base = tree_base(t_q);
		size = tree_size(t_q);
		full = pos_q >= size;
		sidx = 4'(sl_q - 5'd1);
		fc   = 16'(code_q >> (5'd16 - sl_q));
		lfc  = trd_q[33:18];
		lcnt = trd_q[17:9];
		loff = trd_q[8:0];
		d    = lc_q - lfc;
		hit  = (lc_q >= lfc) && (d < 16'(lcnt));

		l_we = (st_q == T_PAIR) && !full;
		l_wa = base + pos_q;
		l_re = (st_q == T_SORT);
		l_ra = base + s_q;
		t_we = (st_q == T_SWEEP);
		t_wa = {t_q, sidx};
		t_wd = {fc, cnt_q[sidx], off_q};
		t_re = (st_q == T_IDLE) && (req.op == OP_LOOK);
		t_ra = {req.tree, 4'(req.clen - 5'd1)};
		s_we = sv_s1;
		s_wa = base + cur_q[lrd_q];
		s_re = (st_q == T_LOOK1) && hit;
		s_ra = base + loff + d[8:0];
	end

	always_ff @(posedge clk) begin
		if (l_we)
			lmem[l_wa] <= len_q;
		if (l_re)
			lrd_q <= lmem[l_ra];
		if (t_we)
			tmem[t_wa] <= t_wd;
		if (t_re)
			trd_q <= tmem[t_ra];
		if (s_we)
			smem[s_wa] <= ss_s1;
		if (s_re)
			srd_q <= smem[s_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= T_IDLE;
			t_q    <= TREE_LIT;
			pos_q  <= '0;
			over_q <= 1'b0;
			for (int i = 0; i < MaxCodeLength; i++) begin
				cnt_q[i] <= '0;
				cur_q[i] <= '0;
			end
			reps_q <= '0;
			len_q  <= '0;
			sl_q   <= '0;
			code_q <= '0;
			off_q  <= '0;
			s_q    <= '0;
			lc_q   <= '0;
			sv_s1  <= 1'b0;
			ss_s1  <= '0;
			done_q <= 1'b0;
			ok_q   <= 1'b0;
			sym_q  <= '0;
		end else begin
			done_q <= 1'b0;
			sv_s1  <= 1'b0;
			if (sv_s1)
				cur_q[lrd_q] <= cur_q[lrd_q] + 9'd1;
			unique case (st_q)
				T_IDLE: begin
					t_q <= req.tree;
					case (req.op)
						OP_PAIR: begin
							reps_q <= 5'(req.pair[7:4]) + 5'd1;
							len_q  <= req.pair[3:0];
							st_q   <= T_PAIR;
						end
						OP_BUILD: begin
							if (over_q || pos_q != tree_size(req.tree)) begin
								done_q <= 1'b1;
								ok_q   <= 1'b0;
								pos_q  <= '0;
								over_q <= 1'b0;
								for (int i = 0; i < MaxCodeLength; i++)
									cnt_q[i] <= '0;
							end else begin
								sl_q   <= 5'(MaxCodeLength);
								code_q <= '0;
								off_q  <= '0;
								st_q   <= T_SWEEP;
							end
						end
						OP_LOOK: begin
							lc_q <= req.code;
							st_q <= T_LOOK1;
						end
						default: ;
					endcase
				end
				T_PAIR: begin
					if (full) begin
						over_q <= 1'b1;
						done_q <= 1'b1;
						st_q   <= T_IDLE;
					end else begin
						cnt_q[len_q] <= cnt_q[len_q] + 9'd1;
						pos_q        <= pos_q + 9'd1;
						reps_q       <= reps_q - 5'd1;
						if (reps_q == 5'd1) begin
							done_q <= 1'b1;
							st_q   <= T_IDLE;
						end
					end
				end
				T_SWEEP: begin
					cur_q[sidx] <= off_q;
					off_q       <= off_q + cnt_q[sidx];
					code_q      <= code_q + (25'(cnt_q[sidx]) << (5'd16 - sl_q));
					sl_q        <= sl_q - 5'd1;
					if (sl_q == 5'd1) begin
						s_q  <= size - 9'd1;
						st_q <= T_SORT;
					end
				end
				T_SORT: begin
					sv_s1 <= 1'b1;
					ss_s1 <= s_q[7:0];
					s_q   <= s_q - 9'd1;
					if (s_q == 9'd0)
						st_q <= T_SORTW;
				end
				T_SORTW: begin
					done_q <= 1'b1;
					ok_q   <= (code_q == 25'h10000);
					pos_q  <= '0;
					over_q <= 1'b0;
					for (int i = 0; i < MaxCodeLength; i++)
						cnt_q[i] <= '0;
					st_q   <= T_IDLE;
				end
				T_LOOK1: begin
					if (hit) begin
						st_q <= T_LOOK2;
					end else begin
						done_q <= 1'b1;
						ok_q   <= 1'b0;
						st_q   <= T_IDLE;
					end
				end
				T_LOOK2: begin
					done_q <= 1'b1;
					ok_q   <= 1'b1;
					sym_q  <= srd_q;
					st_q   <= T_IDLE;
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.ok   = ok_q;
	assign rsp.sym  = sym_q;

endmodule

// ----- rtl/implode_stream_decompressor.sv -----
// Per byte: each header byte after the first (the count byte) goes to the tree as one pair;
// the last byte of a header also starts the tree build, a sweep over code lengths, then a sort.
// A data byte is taken apart field by field: flag and raw fields directly, each code bit
// by a tree lookup, and each copied byte by a window read, then a write (up to 321 per match).
// One byte is worked on at a time; results leave through a one-deep output register.
// Reset clears all control state at once; the window reads as zero until written.
module implode_stream_decompressor
	import idc_pkg::*;
#(
	parameter int WINDOW_DEPTH     = WindowDepth,
	parameter int BYTES_PER_RESULT = BytesPerResult
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic         cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // in_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // bytes_low, bytes_high, byte_count, zero pad
	output logic         m_tuser,  // error
	output logic         m_tlast
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int PW = AW + 1;
	localparam int CW = $clog2(BYTES_PER_RESULT + 1);
	localparam int IW = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

	localparam logic [3:0] C_IDLE   = 4'd0;
	localparam logic [3:0] C_HWAIT  = 4'd1;
	localparam logic [3:0] C_BWAIT  = 4'd2;
	localparam logic [3:0] C_STEP   = 4'd3;
	localparam logic [3:0] C_LWAIT  = 4'd4;
	localparam logic [3:0] C_CSTART = 4'd5;
	localparam logic [3:0] C_CRD    = 4'd6;
	localparam logic [3:0] C_PUT    = 4'd7;
	localparam logic [3:0] C_FIN    = 4'd8;

	logic [3:0]    st_q;
	logic          three_q, large_q;
	logic          lit_q, d7_q, started_q;
	logic [3:0]    phase_q;
	logic [8:0]    hcnt_q;
	logic [7:0]    hb0_q;
	logic [15:0]   res_q;
	logic [4:0]    fill_q;
	logic [15:0]   pc_q;
	logic [4:0]    pl_q;
	logic [6:0]    dl_q;
	logic [5:0]    dh_q;
	logic [5:0]    lc_q;
	logic [7:0]    ex_q;
	logic          err_q;
	logic [7:0]    byte_q;
	logic          copy_q;
	logic [8:0]    len_q;
	logic [AW-1:0] src_q;
	logic [7:0]    buf_q [BYTES_PER_RESULT];
	logic [CW-1:0] bcnt_q;
	logic          ov_q;
	logic [127:0]  od_q;
	logic [4:0]    ocnt_q;
	logic          oerr_q, olast_q;
	tree_req_t     treq_q;
	tree_rsp_t     trsp;

	logic          win_we, win_re;
	logic [7:0]    win_rdata, pb;
	logic [AW-1:0] win_pos;
	logic          out_free, acc, bfull;
	logic [3:0]    eph;
	logic          elit;
	logic [15:0]   npc;
	logic [4:0]    npl;
	logic [13:0]   mdist;
	logic [PW-1:0] distm, posx, srcx;
	logic [127:0]  flat;

	idc_window #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (win_we),
		.wdata  (pb),
		.re     (win_re),
		.raddr  (src_q),
		.rdata  (win_rdata),
		.pos    (win_pos)
	);

	idc_tree u_tree (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (treq_q),
		.rsp    (trsp)
	);

	always_comb begin
		out_free = !ov_q || m_tready;
		acc      = s_tvalid && s_tready;
		bfull    = (bcnt_q == CW'(BYTES_PER_RESULT));
		eph      = started_q ? phase_q : (three_q ? PH_LIT_HDR : PH_LEN_HDR);
		elit     = started_q ? lit_q : three_q;
		npc      = {pc_q[14:0], res_q[0]};
		npl      = pl_q + 5'd1;
		pb       = copy_q ? win_rdata : byte_q;
		win_re   = (st_q == C_CRD);
		win_we   = (st_q == C_PUT) && !bfull;
		mdist    = (d7_q ? {1'b0, dh_q, dl_q} : {2'b0, dh_q, dl_q[5:0]}) + 14'd1;
		distm    = (PW'(mdist) == PW'(WINDOW_DEPTH)) ? '0 : PW'(mdist);
		posx     = PW'(win_pos);
		srcx     = (posx >= distm) ? posx - distm : posx + PW'(WINDOW_DEPTH) - distm;
		flat     = '0;
		for (int i = 0; i < BYTES_PER_RESULT; i++)
			if (CW'(i) < bcnt_q)
				flat[8*i +: 8] = buf_q[i];
	end

	assign s_tready = (st_q == C_IDLE);

	always_ff @(posedge clk) begin
		if (win_we)
			buf_q[bcnt_q[IW-1:0]] <= pb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= C_IDLE;
			three_q   <= 1'b1;
			large_q   <= 1'b1;
			lit_q     <= 1'b1;
			d7_q      <= 1'b1;
			started_q <= 1'b0;
			phase_q   <= PH_LIT_HDR;
			hcnt_q    <= '0;
			hb0_q     <= '0;
			res_q     <= '0;
			fill_q    <= '0;
			pc_q      <= '0;
			pl_q      <= '0;
			dl_q      <= '0;
			dh_q      <= '0;
			lc_q      <= '0;
			ex_q      <= '0;
			err_q     <= 1'b0;
			byte_q    <= '0;
			copy_q    <= 1'b0;
			len_q     <= '0;
			src_q     <= '0;
			bcnt_q    <= '0;
			ov_q      <= 1'b0;
			od_q      <= '0;
			ocnt_q    <= '0;
			oerr_q    <= 1'b0;
			olast_q   <= 1'b0;
			treq_q    <= '0;
		end else begin
			treq_q.op <= OP_NONE;
			if (cfg_we) begin
				if (cfg_index == REG_LARGE_DICT)
					large_q <= cfg_data;
				else
					three_q <= cfg_data;
			end
			if (ov_q && m_tready)
				ov_q <= 1'b0;

			unique case (st_q)
				C_IDLE: begin
					if (acc && eph != PH_STOPPED) begin
						if (!started_q) begin
							started_q <= 1'b1;
							lit_q     <= three_q;
							d7_q      <= large_q;
						end
						phase_q <= eph;
						if (eph <= PH_DIST_HDR) begin
							hcnt_q <= hcnt_q + 9'd1;
							if (hcnt_q == 9'd0) begin
								hb0_q <= s_tdata;
							end else begin
								treq_q.op   <= OP_PAIR;
								treq_q.tree <= eph[1:0];
								treq_q.pair <= s_tdata;
								st_q        <= C_HWAIT;
							end
						end else begin
							res_q  <= res_q | (16'(s_tdata) << fill_q);
							fill_q <= fill_q + 5'd8;
							st_q   <= C_STEP;
						end
					end
				end
				C_HWAIT: begin
					if (trsp.done) begin
						if (hcnt_q == 9'(hb0_q) + 9'd2) begin
							treq_q.op   <= OP_BUILD;
							treq_q.tree <= phase_q[1:0];
							st_q        <= C_BWAIT;
						end else begin
							st_q <= C_IDLE;
						end
					end
				end
				C_BWAIT: begin
					if (trsp.done) begin
						hcnt_q <= '0;
						if (trsp.ok)
							phase_q <= phase_q + 4'd1;
						else
							err_q <= 1'b1;
						st_q <= C_FIN;
					end
				end
				C_STEP: begin
					if (fill_q == 5'd0) begin
						st_q <= C_FIN;
					end else begin
						case (phase_q) inside
							PH_FLAG: begin
								res_q  <= res_q >> 1;
								fill_q <= fill_q - 5'd1;
								if (res_q[0])
									phase_q <= lit_q ? PH_LIT : PH_RAW;
								else
									phase_q <= PH_DLOW;
							end
							PH_LIT, PH_DHIGH, PH_LEN: begin
								res_q       <= res_q >> 1;
								fill_q      <= fill_q - 5'd1;
								pc_q        <= npc;
								pl_q        <= npl;
								treq_q.op   <= OP_LOOK;
								treq_q.code <= npc;
								treq_q.clen <= npl;
								treq_q.tree <= (phase_q == PH_LIT) ? TREE_LIT :
									(phase_q == PH_LEN) ? TREE_LEN : TREE_DIST;
								st_q        <= C_LWAIT;
							end
							PH_RAW: begin
								if (fill_q < 5'd8) begin
									st_q <= C_FIN;
								end else begin
									byte_q <= res_q[7:0];
									res_q  <= res_q >> 8;
									fill_q <= fill_q - 5'd8;
									copy_q <= 1'b0;
									st_q   <= C_PUT;
								end
							end
							PH_DLOW: begin
								if (fill_q < (d7_q ? 5'd7 : 5'd6)) begin
									st_q <= C_FIN;
								end else if (d7_q) begin
									dl_q    <= res_q[6:0];
									res_q   <= res_q >> 7;
									fill_q  <= fill_q - 5'd7;
									phase_q <= PH_DHIGH;
								end else begin
									dl_q    <= {1'b0, res_q[5:0]};
									res_q   <= res_q >> 6;
									fill_q  <= fill_q - 5'd6;
									phase_q <= PH_DHIGH;
								end
							end
							PH_EXTRA: begin
								if (fill_q < 5'd8) begin
									st_q <= C_FIN;
								end else begin
									ex_q   <= res_q[7:0];
									res_q  <= res_q >> 8;
									fill_q <= fill_q - 5'd8;
									st_q   <= C_CSTART;
								end
							end
							default: begin
								err_q <= 1'b1;
								st_q  <= C_FIN;
							end
						endcase
					end
				end
				C_LWAIT: begin
					if (trsp.done) begin
						if (trsp.ok) begin
							pc_q <= '0;
							pl_q <= '0;
							case (phase_q)
								PH_LIT: begin
									byte_q <= trsp.sym;
									copy_q <= 1'b0;
									st_q   <= C_PUT;
								end
								PH_DHIGH: begin
									dh_q    <= trsp.sym[5:0];
									phase_q <= PH_LEN;
									st_q    <= C_STEP;
								end
								default: begin
									lc_q <= trsp.sym[5:0];
									if (trsp.sym[5:0] == LenCodeExtra) begin
										phase_q <= PH_EXTRA;
										st_q    <= C_STEP;
									end else begin
										st_q <= C_CSTART;
									end
								end
							endcase
						end else if (pl_q >= 5'(MaxCodeLength)) begin
							err_q <= 1'b1;
							st_q  <= C_FIN;
						end else begin
							st_q <= C_STEP;
						end
					end
				end
				C_CSTART: begin
					len_q  <= 9'(lc_q) + 9'(ex_q) + (lit_q ? 9'd3 : 9'd2);
					ex_q   <= '0;
					src_q  <= srcx[AW-1:0];
					copy_q <= 1'b1;
					st_q   <= C_CRD;
				end
				C_CRD: begin
					st_q <= C_PUT;
				end
				C_PUT: begin
					if (bfull) begin
						if (out_free) begin
							ov_q    <= 1'b1;
							od_q    <= flat;
							ocnt_q  <= 5'(bcnt_q);
							oerr_q  <= 1'b0;
							olast_q <= 1'b0;
							bcnt_q  <= '0;
						end
					end else begin
						bcnt_q <= bcnt_q + 1'b1;
						if (copy_q) begin
							src_q <= (src_q == AW'(WINDOW_DEPTH - 1)) ? '0 : src_q + 1'b1;
							len_q <= len_q - 9'd1;
							if (len_q == 9'd1) begin
								copy_q  <= 1'b0;
								phase_q <= PH_FLAG;
								st_q    <= C_STEP;
							end else begin
								st_q <= C_CRD;
							end
						end else begin
							phase_q <= PH_FLAG;
							st_q    <= C_STEP;
						end
					end
				end
				C_FIN: begin
					if (bcnt_q != '0 || err_q) begin
						if (out_free) begin
							ov_q    <= 1'b1;
							od_q    <= flat;
							ocnt_q  <= 5'(bcnt_q);
							oerr_q  <= err_q;
							olast_q <= 1'b1;
							bcnt_q  <= '0;
							if (err_q)
								phase_q <= PH_STOPPED;
							err_q <= 1'b0;
							st_q  <= C_IDLE;
						end
					end else begin
						st_q <= C_IDLE;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {3'b000, ocnt_q, od_q};
	assign m_tuser  = oerr_q;
	assign m_tlast  = olast_q;

endmodule

// ----- tb/sv/tb.sv -----
module tb;
	import idc_pkg::*;

	localparam int DRAIN_CYCLES    = 700;
	localparam int WATCHDOG_LIMIT  = 5000;

	typedef struct {
		bit [63:0] lo;
		bit [63:0] hi;
		bit [4:0]  cnt;
		bit        err;
		bit        last;
	} chunk_t;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic         cfg_index;
	logic         cfg_data;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         m_tuser;
	logic         m_tlast;

	implode_stream_decompressor DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	bit [7:0] feed_q[$];
	chunk_t   chunk_q[$];
	int       errors;
	bit       calm;
	bit       in_fire;
	int       sgap, rgap, idle_cycles;

	// decoder copy
	bit          cfg_tt, cfg_ld, started, lit_mode, dict7;
	bit [7:0]    win[WindowDepth];
	int unsigned wpos;
	bit [7:0]    hdr[257];
	int unsigned hcnt;
	bit [4:0]    clen[384];
	bit [7:0]    ssym[384];
	int unsigned first_code[51], len_count[51], sym_off[51];
	int unsigned reservoir, fill;
	logic [3:0]  phase;
	int unsigned pcode, plen, dlow, dhigh, lcode, xlen;
	bit [7:0]    produced[$];

	function automatic void put_byte(bit [7:0] b);
		win[wpos] = b;
		wpos = (wpos + 1) % WindowDepth;
		produced.push_back(b);
	endfunction

	function automatic int unsigned take_bits(int unsigned n);
		int unsigned v;
		v = reservoir & ((32'd1 << n) - 1);
		reservoir = reservoir >> n;
		fill = fill - n;
		return v;
	endfunction

	function automatic bit build_tree(logic [1:0] t);
		int unsigned base, n, pos, last, b, reps, len, code, off, idx;
		base = tree_base(t);
		n = tree_size(t);
		pos = 0;
		last = hdr[0] + 1;
		for (int unsigned i = 1; i <= last && i < 257; i++) begin
			b = hdr[i];
			reps = (b >> 4) + 1;
			len = (b & 4'hf) + 1;
			for (int unsigned r = 0; r < reps; r++) begin
				if (pos >= n)
					return 1'b0;
				clen[base + pos] = len[4:0];
				pos++;
			end
		end
		if (pos != n)
			return 1'b0;
		for (int unsigned l = 0; l <= MaxCodeLength; l++)
			len_count[t * 17 + l] = 0;
		for (int unsigned s = 0; s < n; s++)
			len_count[t * 17 + clen[base + s] % 17]++;
		pos = 0;
		code = 0;
		off = 0;
		for (int l = MaxCodeLength; l >= 1; l--) begin
			idx = t * 17 + l;
			sym_off[idx] = off;
			off += len_count[idx];
			first_code[idx] = code >> (16 - l);
			code += len_count[idx] << (16 - l);
			for (int unsigned s = n; s > 0; s--)
				if (clen[base + s - 1] == l) begin
					ssym[base + pos] = 8'(s - 1);
					pos++;
				end
		end
		return code == 32'h10000;
	endfunction

	function automatic int tree_bit(logic [1:0] t, int unsigned b, output int unsigned sym);
		int unsigned idx, d;
		sym = 0;
		pcode = ((pcode << 1) | b) & 16'hffff;
		plen++;
		if (plen > MaxCodeLength)
			return -1;
		idx = t * 17 + plen;
		d = pcode - first_code[idx];
		if (pcode >= first_code[idx] && d < len_count[idx]) begin
			sym = ssym[(tree_base(t) + sym_off[idx] + d) % 384];
			pcode = 0;
			plen = 0;
			return 1;
		end
		return plen >= MaxCodeLength ? -1 : 0;
	endfunction

	function automatic void decode_byte(bit [7:0] b);
		bit          err, stall, copy;
		int          r;
		int unsigned s, mdist, len, src, nres, cnt;
		chunk_t      c;
		err = 0;
		produced.delete();
		if (phase == PH_STOPPED)
			return;
		if (!started) begin
			started = 1;
			lit_mode = cfg_tt;
			dict7 = cfg_ld;
			phase = lit_mode ? PH_LIT_HDR : PH_LEN_HDR;
		end
		if (phase <= PH_DIST_HDR) begin
			if (hcnt < 257) begin
				hdr[hcnt] = b;
				hcnt++;
			end
			if (hcnt == hdr[0] + 2) begin
				if (!build_tree(phase[1:0]))
					err = 1;
				else
					phase = phase + 4'd1;
				hcnt = 0;
			end
		end else begin
			reservoir |= b << fill;
			fill += 8;
			while (fill > 0 && !err) begin
				stall = 0;
				copy = 0;
				case (phase)
					PH_FLAG: begin
						phase = take_bits(1) ? (lit_mode ? PH_LIT : PH_RAW) : PH_DLOW;
					end
					PH_LIT: begin
						r = tree_bit(TREE_LIT, take_bits(1), s);
						if (r < 0) err = 1;
						else if (r > 0) begin
							put_byte(s[7:0]);
							phase = PH_FLAG;
						end
					end
					PH_RAW: begin
						if (fill < 8) stall = 1;
						else begin
							put_byte(8'(take_bits(8)));
							phase = PH_FLAG;
						end
					end
					PH_DLOW: begin
						if (fill < (dict7 ? 7 : 6)) stall = 1;
						else begin
							dlow = take_bits(dict7 ? 7 : 6);
							phase = PH_DHIGH;
						end
					end
					PH_DHIGH: begin
						r = tree_bit(TREE_DIST, take_bits(1), s);
						if (r < 0) err = 1;
						else if (r > 0) begin
							dhigh = s & 6'h3f;
							phase = PH_LEN;
						end
					end
					PH_LEN: begin
						r = tree_bit(TREE_LEN, take_bits(1), s);
						if (r < 0) err = 1;
						else if (r > 0) begin
							lcode = s & 6'h3f;
							if (lcode == LenCodeExtra) phase = PH_EXTRA;
							else copy = 1;
						end
					end
					PH_EXTRA: begin
						if (fill < 8) stall = 1;
						else begin
							xlen = take_bits(8);
							copy = 1;
						end
					end
					default: err = 1;
				endcase
				if (stall)
					break;
				if (copy) begin
					mdist = (dlow | (dhigh << (dict7 ? 7 : 6))) + 1;
					len = lcode + xlen + (lit_mode ? 3 : 2);
					src = (wpos + WindowDepth - mdist % WindowDepth) % WindowDepth;
					xlen = 0;
					while (len > 0) begin
						put_byte(win[src]);
						src = (src + 1) % WindowDepth;
						len--;
					end
					phase = PH_FLAG;
				end
			end
		end
		if (err)
			phase = PH_STOPPED;
		nres = (produced.size() + BytesPerResult - 1) / BytesPerResult;
		if (err && nres == 0)
			nres = 1;
		for (int unsigned k = 0; k < nres; k++) begin
			c.lo = '0;
			c.hi = '0;
			cnt = produced.size() > k * BytesPerResult ? produced.size() - k * BytesPerResult : 0;
			if (cnt > BytesPerResult)
				cnt = BytesPerResult;
			for (int unsigned j = 0; j < cnt; j++)
				if (j < 8) c.lo[8 * j +: 8] = produced[k * BytesPerResult + j];
				else c.hi[8 * (j - 8) +: 8] = produced[k * BytesPerResult + j];
			c.cnt = cnt[4:0];
			c.err = err && (k + 1 == nres);
			c.last = (k + 1 == nres);
			chunk_q.push_back(c);
		end
	endfunction

	function automatic void check_field(string name, bit [63:0] want, bit [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		chunk_t c;
		in_fire = s_tvalid && s_tready;
		if (in_fire) begin
			decode_byte(s_tdata);
			void'(feed_q.pop_front());
		end
		if (m_tvalid && m_tready) begin
			if (chunk_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				errors++;
			end else begin
				c = chunk_q.pop_front();
				check_field("bytes_low", c.lo, m_tdata[63:0]);
				check_field("bytes_high", c.hi, m_tdata[127:64]);
				check_field("byte_count", c.cnt, m_tdata[132:128]);
				check_field("error", c.err, m_tuser);
				check_field("last", c.last, m_tlast);
			end
		end
		if (in_fire || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (s_tvalid && !in_fire) begin
		end else if (!calm && sgap > 0) begin
			s_tvalid <= 1'b0;
			sgap--;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			sgap = $urandom_range(0, 6);
		end else if (feed_q.size() > 0) begin
			s_tvalid <= 1'b1;
			s_tdata <= feed_q[0];
		end else
			s_tvalid <= 1'b0;
	end

	always @(negedge clk) begin
		if (calm || !arst_n)
			m_tready <= 1'b1;
		else if (rgap > 0) begin
			m_tready <= 1'b0;
			rgap--;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rgap = $urandom_range(0, 6);
		end else
			m_tready <= 1'b1;
	end

	task automatic write_reg(bit idx, bit val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_THREE_TREES) cfg_tt = val;
		else cfg_ld = val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic add_tree(int n, bit alt);
		if (n == 64) begin
			feed_q.push_back(8'd3);
			feed_q.push_back(alt ? 8'hf4 : 8'hf5);
			feed_q.push_back(8'hf5);
			feed_q.push_back(alt ? 8'hf6 : 8'hf5);
			feed_q.push_back(alt ? 8'hf6 : 8'hf5);
		end else begin
			feed_q.push_back(8'd15);
			for (int i = 0; i < 16; i++)
				feed_q.push_back(alt ? (i < 4 ? 8'hf6 : i < 8 ? 8'hf7 : 8'hf8) : 8'hf7);
		end
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			feed_q.push_back($urandom_range(0, 255));
	endtask

	task automatic drain;
		while (feed_q.size() > 0 || chunk_q.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		bit tt, ld;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'd0;
		m_tready = 1'b0;
		errors = 0;
		calm = 0;
		in_fire = 0;
		sgap = 0;
		rgap = 0;
		idle_cycles = 0;
		cfg_tt = 1;
		cfg_ld = 1;
		started = 0;
		wpos = 0;
		hcnt = 0;
		reservoir = 0;
		fill = 0;
		phase = PH_LIT_HDR;
		pcode = 0;
		plen = 0;
		dlow = 0;
		dhigh = 0;
		lcode = 0;
		xlen = 0;
		foreach (win[i]) win[i] = 8'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		tt = $urandom_range(0, 1);
		ld = $urandom_range(0, 1);
		write_reg(REG_THREE_TREES, tt);
		write_reg(REG_LARGE_DICT, ld);
		// headers: literal tree only with three trees
		if (tt)
			add_tree(256, $urandom_range(0, 1));
		add_tree(64, $urandom_range(0, 1));
		add_tree(64, $urandom_range(0, 1));
		feed_q.push_back(8'h00);
		feed_q.push_back(8'hff);
		feed_q.push_back(8'h55);
		feed_q.push_back(8'haa);
		add_random(40);
		drain();
		// settings are latched on the first transfer, so these are don't-care
		write_reg(REG_THREE_TREES, !tt);
		write_reg(REG_LARGE_DICT, !ld);
		add_random(50);
		drain();
		write_reg(REG_THREE_TREES, 1'b0);
		write_reg(REG_LARGE_DICT, 1'b1);
		calm = 1;
		add_random(30);
		drain();
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/idc_pkg.sv
rtl/idc_window.sv
rtl/idc_tree.sv
rtl/implode_stream_decompressor.sv
tb/sv/tb.sv
